/* sv/assert_macros.svh */
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define VRT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every rising edge, reset included.
`define VRT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* sv/vrt_pkg.sv */
package vrt_pkg;

   localparam int AddrWidth = 5;
   localparam int DataWidth = 32;
   localparam int RetraceBit = 5;

   typedef enum logic [2:0] {
      REG_ACTIVE_LINES    = 3'd0,
      REG_LINE_PERIOD     = 3'd1,
      REG_BLANKING_PERIOD = 3'd2,
      REG_BLINK_PERIOD    = 3'd3,
      REG_PENALTY_CYCLES  = 3'd4
   } reg_index_type;

   typedef enum logic {
      REQ_TIME = 1'b0,
      REQ_POLL = 1'b1
   } req_kind_type;

   localparam logic [7:0]  ActiveLinesReset    = 8'd200;
   localparam logic [11:0] LinePeriodReset     = 12'd250;
   localparam logic [14:0] BlankingPeriodReset = 15'd14016;
   localparam logic [5:0]  BlinkPeriodReset    = 6'd30;
   localparam logic [7:0]  PenaltyCyclesReset  = 8'd67;

   localparam logic [1:0]  DmaIdle  = 2'b00;
   localparam logic [15:0] AccumMax = 16'hFFFF;

   typedef struct packed {
      logic [7:0]  active_lines;
      logic [11:0] line_period;
      logic [14:0] blanking_period;
      logic [5:0]  blink_period;
      logic [7:0]  penalty_cycles;
   } cfg_type;

endpackage

/* sv/vrt_csr.sv */
module vrt_csr import vrt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [AddrWidth-1:0] paddr,
   input  logic [DataWidth-1:0] pwdata,
   output logic [DataWidth-1:0] prdata,
   output logic                 pready,
   output cfg_type              cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_sel;
   logic          write_en;

   assign reg_sel  = reg_index_type'(paddr[AddrWidth-1:2]);
   assign write_en = psel & penable & pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_sel)
            REG_ACTIVE_LINES:    cfg_in.active_lines    = pwdata[7:0];
            REG_LINE_PERIOD:     cfg_in.line_period     = pwdata[11:0];
            REG_BLANKING_PERIOD: cfg_in.blanking_period = pwdata[14:0];
            REG_BLINK_PERIOD:    cfg_in.blink_period    = pwdata[5:0];
            REG_PENALTY_CYCLES:  cfg_in.penalty_cycles  = pwdata[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_ACTIVE_LINES:    prdata = DataWidth'(cfg_ff.active_lines);
         REG_LINE_PERIOD:     prdata = DataWidth'(cfg_ff.line_period);
         REG_BLANKING_PERIOD: prdata = DataWidth'(cfg_ff.blanking_period);
         REG_BLINK_PERIOD:    prdata = DataWidth'(cfg_ff.blink_period);
         REG_PENALTY_CYCLES:  prdata = DataWidth'(cfg_ff.penalty_cycles);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_lines    <= ActiveLinesReset;
         cfg_ff.line_period     <= LinePeriodReset;
         cfg_ff.blanking_period <= BlankingPeriodReset;
         cfg_ff.blink_period    <= BlinkPeriodReset;
         cfg_ff.penalty_cycles  <= PenaltyCyclesReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* sv/video_retrace_timing.sv */
// An input item reaches its result through the input register, then the result register.
// Throughput: one item per cycle unless stalled; timing state updates as an item moves into
// the result register, so consecutive items chain through one add, compare and subtract.
// Reset (synchronous): clears both stages and the timing state, and loads the
// configuration registers with their default values.
module video_retrace_timing import vrt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [AddrWidth-1:0] paddr,
   input  logic [DataWidth-1:0] pwdata,
   output logic [DataWidth-1:0] prdata,
   output logic                 pready,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_type,
   input  logic [11:0]          req_ticks,
   input  logic [7:0]           req_port_in,
   input  logic [1:0]           req_display_dma_bits,
   input  logic                 req_cursor_enabled,
   input  logic [4:0]           req_cursor_row,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_port_out,
   output logic                 rsp_vblank_started,
   output logic [7:0]           rsp_dma_penalty,
   output logic                 rsp_retrace_flag,
   output logic                 rsp_cursor_phase,
   output logic                 rsp_redraw_valid,
   output logic [4:0]           rsp_redraw_row
);

   cfg_type cfg;

   vrt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   logic         s1_valid_ff, s1_valid_in;
   req_kind_type s1_kind_ff;
   logic [11:0]  s1_ticks_ff;
   logic [7:0]   s1_port_ff;
   logic [1:0]   s1_dma_ff;
   logic         s1_cen_ff;
   logic [4:0]   s1_row_ff;

   logic [7:0]  line_count_ff, line_count_in;
   logic [15:0] line_accum_ff, line_accum_in;
   logic [15:0] blank_accum_ff, blank_accum_in;
   logic        retrace_ff, retrace_in;
   logic [5:0]  blink_count_ff, blink_count_in;
   logic        blink_phase_ff, blink_phase_in;
   logic [7:0]  penalty_ff, penalty_in;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_port_ff, out_port_in;
   logic        out_vstart_ff, out_vstart_in;
   logic        out_redraw_ff, out_redraw_in;
   logic [4:0]  out_row_ff, out_row_in;

   logic        advance, load_s1;
   logic [16:0] line_sum, blank_sum;
   logic [15:0] line_sat, blank_sat;
   logic [5:0]  blink_inc;

   assign advance   = s1_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~advance;
   assign load_s1   = req_valid & ~req_stall;

   assign s1_valid_in  = load_s1 | (s1_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & rsp_stall);

   assign line_sum  = {1'b0, line_accum_ff} + 17'(s1_ticks_ff);
   assign blank_sum = {1'b0, blank_accum_ff} + 17'(s1_ticks_ff);
   assign line_sat  = line_sum[16] ? AccumMax : line_sum[15:0];
   assign blank_sat = blank_sum[16] ? AccumMax : blank_sum[15:0];
   assign blink_inc = blink_count_ff + 6'd1;

   always_comb begin
      line_count_in  = line_count_ff;
      line_accum_in  = line_accum_ff;
      blank_accum_in = blank_accum_ff;
      retrace_in     = retrace_ff;
      blink_count_in = blink_count_ff;
      blink_phase_in = blink_phase_ff;
      penalty_in     = penalty_ff;
      out_port_in    = '0;
      out_vstart_in  = 1'b0;
      out_redraw_in  = 1'b0;
      if (s1_kind_ff == REQ_POLL) begin
         out_port_in             = s1_port_ff;
         out_port_in[RetraceBit] = retrace_ff;
      end else if (line_count_ff < cfg.active_lines) begin
         line_accum_in = line_sat;
         if (line_sat >= 16'(cfg.line_period)) begin
            penalty_in    = (s1_dma_ff == DmaIdle) ? cfg.penalty_cycles : 8'd0;
            line_count_in = line_count_ff + 8'd1;
            if (line_count_in >= cfg.active_lines) begin
               blank_accum_in = '0;
               retrace_in     = 1'b1;
               out_vstart_in  = 1'b1;
               blink_count_in = blink_inc;
               if (blink_inc >= cfg.blink_period) begin
                  blink_count_in = '0;
                  blink_phase_in = ~blink_phase_ff;
                  out_redraw_in  = s1_cen_ff;
               end
            end else begin
               line_accum_in = line_sat - 16'(cfg.line_period);
            end
         end
      end else begin
         blank_accum_in = blank_sat;
         if (blank_sat > 16'(cfg.blanking_period)) begin
            line_count_in = '0;
            line_accum_in = blank_sat - 16'(cfg.blanking_period);
            retrace_in    = 1'b0;
         end
      end
      out_row_in = out_redraw_in ? s1_row_ff : 5'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         line_count_ff  <= '0;
         line_accum_ff  <= '0;
         blank_accum_ff <= '0;
         retrace_ff     <= 1'b0;
         blink_count_ff <= '0;
         blink_phase_ff <= 1'b0;
         penalty_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            line_count_ff  <= line_count_in;
            line_accum_ff  <= line_accum_in;
            blank_accum_ff <= blank_accum_in;
            retrace_ff     <= retrace_in;
            blink_count_ff <= blink_count_in;
            blink_phase_ff <= blink_phase_in;
            penalty_ff     <= penalty_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_kind_ff  <= req_kind_type'(req_type);
         s1_ticks_ff <= req_ticks;
         s1_port_ff  <= req_port_in;
         s1_dma_ff   <= req_display_dma_bits;
         s1_cen_ff   <= req_cursor_enabled;
         s1_row_ff   <= req_cursor_row;
      end
      if (advance) begin
         out_port_ff   <= out_port_in;
         out_vstart_ff <= out_vstart_in;
         out_redraw_ff <= out_redraw_in;
         out_row_ff    <= out_row_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_port_out       = out_port_ff;
   assign rsp_vblank_started = out_vstart_ff;
   assign rsp_dma_penalty    = penalty_ff;
   assign rsp_retrace_flag   = retrace_ff;
   assign rsp_cursor_phase   = blink_phase_ff;
   assign rsp_redraw_valid   = out_redraw_ff;
   assign rsp_redraw_row     = out_row_ff;

endmodule

/* sv/vrt_checker.sv */
`include "assert_macros.svh"

module vrt_checker import vrt_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_port_out,
   input logic       rsp_vblank_started,
   input logic       rsp_retrace_flag,
   input logic       rsp_redraw_valid,
   input logic [4:0] rsp_redraw_row
);

   `VRT_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid right after reset")
   `VRT_ASSERT(a_redraw_at_vstart, rsp_valid && rsp_redraw_valid |-> rsp_vblank_started, "redraw without blanking start")
   `VRT_ASSERT(a_vstart_retrace, rsp_valid && rsp_vblank_started |-> rsp_retrace_flag && (rsp_port_out == 8'd0), "blanking start without retrace or with port byte")
   `VRT_ASSERT(a_row_zero, rsp_valid && !rsp_redraw_valid |-> rsp_redraw_row == 5'd0, "redraw row set without redraw")
   `VRT_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_port_out) && $stable(rsp_redraw_row), "stalled result changed")

endmodule

bind video_retrace_timing vrt_checker u_vrt_checker (.*);

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench import vrt_pkg::*; ();

   typedef struct packed {
      req_kind_type kind;
      logic [11:0]  ticks;
      logic [7:0]   port_in;
      logic [1:0]   dma;
      logic         cursor_en;
      logic [4:0]   cursor_row;
   } timing_req_type;

   typedef struct packed {
      logic [7:0] port_out;
      logic       vblank_started;
      logic [7:0] dma_penalty;
      logic       retrace;
      logic       phase;
      logic       redraw_valid;
      logic [4:0] redraw_row;
   } timing_rsp_type;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_ALTERNATE,
      STALL_LONG
   } stall_mode_type;

   localparam int WatchdogLimit = 4000;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [AddrWidth-1:0] paddr = '0;
   logic [DataWidth-1:0] pwdata = '0;
   logic [DataWidth-1:0] prdata;
   logic                 pready;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_type = 1'b0;
   logic [11:0]          req_ticks = '0;
   logic [7:0]           req_port_in = '0;
   logic [1:0]           req_display_dma_bits = '0;
   logic                 req_cursor_enabled = 1'b0;
   logic [4:0]           req_cursor_row = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [7:0]           rsp_port_out;
   logic                 rsp_vblank_started;
   logic [7:0]           rsp_dma_penalty;
   logic                 rsp_retrace_flag;
   logic                 rsp_cursor_phase;
   logic                 rsp_redraw_valid;
   logic [4:0]           rsp_redraw_row;

   timing_req_type pending_reqs[$];
   timing_rsp_type expected_rsps[$];
   timing_req_type req_cur;

   cfg_type     timing_cfg;
   logic [7:0]  line_count;
   logic [15:0] line_accum;
   logic [15:0] blank_accum;
   logic        retrace_on;
   logic [5:0]  blink_count;
   logic        blink_phase;
   logic [7:0]  penalty_held;

   int             errors = 0;
   int             rsp_count = 0;
   int             idle_cycles = 0;
   int             burst_left;
   int             gap_left;
   logic [7:0]     pattern_tick;
   stall_mode_type stall_mode;

   video_retrace_timing i_dut (
      .clock                (clock),
      .reset                (reset),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_ticks            (req_ticks),
      .req_port_in          (req_port_in),
      .req_display_dma_bits (req_display_dma_bits),
      .req_cursor_enabled   (req_cursor_enabled),
      .req_cursor_row       (req_cursor_row),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_port_out         (rsp_port_out),
      .rsp_vblank_started   (rsp_vblank_started),
      .rsp_dma_penalty      (rsp_dma_penalty),
      .rsp_retrace_flag     (rsp_retrace_flag),
      .rsp_cursor_phase     (rsp_cursor_phase),
      .rsp_redraw_valid     (rsp_redraw_valid),
      .rsp_redraw_row       (rsp_redraw_row)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic timing_rsp_type predict_timing(timing_req_type r);
      timing_rsp_type o;
      logic [16:0] sum;
      o = '0;
      if (r.kind == REQ_POLL) begin
         o.port_out = r.port_in;
         o.port_out[RetraceBit] = retrace_on;
      end else if (line_count < timing_cfg.active_lines) begin
         sum = {1'b0, line_accum} + 17'(r.ticks);
         line_accum = (sum > 17'(AccumMax)) ? AccumMax : sum[15:0];
         if (line_accum >= 16'(timing_cfg.line_period)) begin
            penalty_held = (r.dma == DmaIdle) ? timing_cfg.penalty_cycles : 8'd0;
            line_count = line_count + 8'd1;
            if (line_count >= timing_cfg.active_lines) begin
               blank_accum = '0;
               retrace_on = 1'b1;
               o.vblank_started = 1'b1;
               blink_count = blink_count + 6'd1;
               if (blink_count >= timing_cfg.blink_period) begin
                  blink_count = '0;
                  blink_phase = ~blink_phase;
                  if (r.cursor_en) begin
                     o.redraw_valid = 1'b1;
                     o.redraw_row = r.cursor_row;
                  end
               end
            end else begin
               line_accum = line_accum - 16'(timing_cfg.line_period);
            end
         end
      end else begin
         sum = {1'b0, blank_accum} + 17'(r.ticks);
         blank_accum = (sum > 17'(AccumMax)) ? AccumMax : sum[15:0];
         if (blank_accum > 16'(timing_cfg.blanking_period)) begin
            line_count = '0;
            line_accum = blank_accum - 16'(timing_cfg.blanking_period);
            retrace_on = 1'b0;
         end
      end
      o.dma_penalty = penalty_held;
      o.retrace = retrace_on;
      o.phase = blink_phase;
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at result %0d: %s got %0d expected %0d", rsp_count, what, got, want);
      errors++;
   endtask

   task automatic check_result(timing_rsp_type want);
      if (rsp_port_out !== want.port_out)
         report_mismatch("port_out", int'(rsp_port_out), int'(want.port_out));
      if (rsp_vblank_started !== want.vblank_started)
         report_mismatch("vblank_started", int'(rsp_vblank_started),
                         int'(want.vblank_started));
      if (rsp_dma_penalty !== want.dma_penalty)
         report_mismatch("dma_penalty", int'(rsp_dma_penalty), int'(want.dma_penalty));
      if (rsp_retrace_flag !== want.retrace)
         report_mismatch("retrace_flag", int'(rsp_retrace_flag), int'(want.retrace));
      if (rsp_cursor_phase !== want.phase)
         report_mismatch("cursor_phase", int'(rsp_cursor_phase), int'(want.phase));
      if (rsp_redraw_valid !== want.redraw_valid)
         report_mismatch("redraw_valid", int'(rsp_redraw_valid), int'(want.redraw_valid));
      if (rsp_redraw_row !== want.redraw_row)
         report_mismatch("redraw_row", int'(rsp_redraw_row), int'(want.redraw_row));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 1;
         gap_left = 0;
         line_count = '0;
         line_accum = '0;
         blank_accum = '0;
         retrace_on = 1'b0;
         blink_count = '0;
         blink_phase = 1'b0;
         penalty_held = '0;
      end else begin
         if (req_valid && !req_stall)
            expected_rsps.push_back(predict_timing(req_cur));
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_cur = pending_reqs.pop_front();
               req_type <= req_cur.kind;
               req_ticks <= req_cur.ticks;
               req_port_in <= req_cur.port_in;
               req_display_dma_bits <= req_cur.dma;
               req_cursor_enabled <= req_cur.cursor_en;
               req_cursor_row <= req_cur.cursor_row;
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  case ($urandom_range(0, 7))
                     0, 1, 2: gap_left = 0;
                     7:       gap_left = $urandom_range(15, 30);
                     default: gap_left = $urandom_range(1, 6);
                  endcase
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         pattern_tick = '0;
         stall_mode = STALL_NONE;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (expected_rsps.size() == 0)
               report_mismatch("transfer with nothing expected", 1, 0);
            else
               check_result(expected_rsps.pop_front());
         end
         pattern_tick = pattern_tick + 8'd1;
         if (pattern_tick[5:0] == 6'd0)
            stall_mode = stall_mode_type'($urandom_range(0, 3));
         case (stall_mode)
            STALL_NONE:      rsp_stall <= 1'b0;
            STALL_RANDOM:    rsp_stall <= ($urandom_range(0, 2) == 0);
            STALL_ALTERNATE: rsp_stall <= pattern_tick[0];
            default:         rsp_stall <= (pattern_tick[4:0] < 5'd18);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WatchdogLimit);
      $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
      $display("testbench: done, errors");
      $finish;
   end

   function automatic cfg_type make_cfg(int al, int lp, int bp, int bk, int pc);
      cfg_type c;
      c.active_lines = al[7:0];
      c.line_period = lp[11:0];
      c.blanking_period = bp[14:0];
      c.blink_period = bk[5:0];
      c.penalty_cycles = pc[7:0];
      return c;
   endfunction

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(reg_index_type idx, logic [DataWidth-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_ACTIVE_LINES:    timing_cfg.active_lines = value[7:0];
         REG_LINE_PERIOD:     timing_cfg.line_period = value[11:0];
         REG_BLANKING_PERIOD: timing_cfg.blanking_period = value[14:0];
         REG_BLINK_PERIOD:    timing_cfg.blink_period = value[5:0];
         REG_PENALTY_CYCLES:  timing_cfg.penalty_cycles = value[7:0];
         default: ;
      endcase
   endtask

   task automatic set_timing_cfg(cfg_type c);
      wait_idle();
      write_csr(REG_ACTIVE_LINES, DataWidth'(c.active_lines));
      write_csr(REG_LINE_PERIOD, DataWidth'(c.line_period));
      write_csr(REG_BLANKING_PERIOD, DataWidth'(c.blanking_period));
      write_csr(REG_BLINK_PERIOD, DataWidth'(c.blink_period));
      write_csr(REG_PENALTY_CYCLES, DataWidth'(c.penalty_cycles));
   endtask

   task automatic queue_item(req_kind_type kind, int ticks, int port, int dma, int en, int row);
      timing_req_type r;
      r.kind = kind;
      r.ticks = ticks[11:0];
      r.port_in = port[7:0];
      r.dma = dma[1:0];
      r.cursor_en = en[0];
      r.cursor_row = row[4:0];
      pending_reqs.push_back(r);
   endtask

   task automatic queue_random_items(int count, int big_pct);
      int r;
      int ticks;
      req_kind_type kind;
      for (int i = 0; i < count; i++) begin
         kind = ($urandom_range(0, 99) < 20) ? REQ_POLL : REQ_TIME;
         r = $urandom_range(0, 99);
         if (r < big_pct)
            ticks = $urandom_range(3800, 4095);
         else if (r < big_pct + 25)
            ticks = $urandom_range(0, 31);
         else
            ticks = $urandom_range(0, 4095);
         queue_item(kind, ticks, $urandom_range(0, 255), $urandom_range(0, 3),
                    $urandom_range(0, 1), $urandom_range(0, 31));
      end
   endtask

   initial begin
      timing_cfg = make_cfg(int'(ActiveLinesReset), int'(LinePeriodReset),
                            int'(BlankingPeriodReset), int'(BlinkPeriodReset),
                            int'(PenaltyCyclesReset));
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: one line just short, then the line ends
      queue_item(REQ_POLL, 0, 'hFF, 0, 0, 0);
      queue_item(REQ_TIME, 249, 0, 0, 0, 0);
      queue_item(REQ_TIME, 1, 0, 0, 0, 0);

      set_timing_cfg(make_cfg(2, 10, 20, 1, 255));
      queue_item(REQ_TIME, 0, 0, 3, 0, 0);
      queue_item(REQ_TIME, 4095, 'hFF, 0, 1, 31);
      queue_item(REQ_POLL, 0, 'h00, 0, 0, 0);
      queue_item(REQ_POLL, 4095, 'hDF, 3, 1, 31);
      queue_item(REQ_TIME, 20, 0, 0, 0, 0);
      queue_item(REQ_TIME, 1, 0, 0, 0, 0);
      queue_item(REQ_TIME, 4095, 0, 1, 0, 0);
      queue_item(REQ_TIME, 0, 0, 2, 0, 17);
      queue_item(REQ_TIME, 4095, 0, 0, 1, 0);
      queue_item(REQ_TIME, 0, 0, 0, 1, 0);
      queue_item(REQ_TIME, 0, 0, 0, 1, 21);
      queue_item(REQ_POLL, 0, 'h55, 0, 0, 0);

      // no display lines: every time item is blanking
      set_timing_cfg(make_cfg(0, 0, 0, 0, 0));
      queue_item(REQ_TIME, 0, 0, 0, 0, 0);
      queue_item(REQ_TIME, 1, 0, 0, 0, 0);
      queue_item(REQ_POLL, 0, 'hAA, 0, 0, 0);
      queue_item(REQ_TIME, 4095, 0, 0, 1, 31);

      // zero line and blink periods: each display item ends a line
      set_timing_cfg(make_cfg(3, 0, 5, 0, 8));
      queue_item(REQ_TIME, 0, 0, 0, 0, 0);
      queue_item(REQ_TIME, 0, 0, 3, 0, 0);
      queue_item(REQ_TIME, 0, 0, 0, 1, 10);
      queue_item(REQ_TIME, 6, 0, 0, 0, 0);
      queue_item(REQ_TIME, 0, 0, 0, 1, 5);

      // saturate the line accumulator
      set_timing_cfg(make_cfg(255, 1, 32767, 63, 255));
      queue_random_items(110, 80);

      set_timing_cfg(make_cfg(1, 4095, 32767, 63, 0));
      queue_random_items(100, 60);

      for (int p = 0; p < 6; p++) begin
         set_timing_cfg(make_cfg($urandom_range(0, 6), $urandom_range(0, 600),
                                 $urandom_range(0, 3000), $urandom_range(0, 4),
                                 $urandom_range(0, 255)));
         queue_random_items(90, 10);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (expected_rsps.size() != 0)
         report_mismatch("results never arrived", 0, expected_rsps.size());
      if (errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/vrt_pkg.sv
sv/vrt_csr.sv
sv/video_retrace_timing.sv
sv/vrt_checker.sv
test/testbench.sv
